>>> rtl/srr_pkg.sv
// ----------------------------------------------------------------------------
// srr_pkg: shared types and constants of the selective repeat receiver
// Field widths, sequence space, checksum constants, the beat structs on the
// ports and the command/status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package srr_pkg;

    // sequence space and field widths
    localparam int SEQ_SPACE  = 64;
    localparam int HALF_SPACE = SEQ_SPACE / 2;
    localparam int SEQ_W      = 6;
    localparam int SLOT_DEPTH = 64;
    localparam int SLOT_W     = 6;
    localparam int WIN_W      = 6;
    localparam int CNT_W      = 6;
    localparam int DATA_W     = 64;
    localparam int CHK_W      = 16;

    // Fletcher-16 over eight bytes, sums modulo 255
    localparam int BYTE_W     = 8;
    localparam int NBYTES     = 8;
    localparam int BIDX_W     = 3;
    localparam int CSUM_MOD   = 255;

    // window register reset value
    localparam logic [WIN_W-1:0] WIN_RESET = WIN_W'(15);

    // result kinds
    localparam logic KIND_ACK     = 1'b0;
    localparam logic KIND_DELIVER = 1'b1;

    typedef struct packed {
        logic [SEQ_W-1:0]  seq_num;
        logic [DATA_W-1:0] payload;
        logic [CHK_W-1:0]  check_value;
    } t_item;

    typedef struct packed {
        logic              kind;
        logic [SEQ_W-1:0]  out_seq;
        logic [DATA_W-1:0] out_payload;
        logic              last;
    } t_result;

    // controller -> datapath
    typedef struct packed {
        logic load;       // capture input beat, clear sums
        logic csum_step;  // fold one byte into the checksum
        logic ack;        // emit acknowledgement
        logic ack_last;   // acknowledgement ends the item
        logic store;      // store payload in its slot unless held
        logic rd_first;   // read slot at the base
        logic deliver;    // emit the base payload, advance the base
    } t_dp_cmd;

    // datapath -> controller
    typedef struct packed {
        logic csum_last;  // last byte being folded
        logic pkt_good;   // checksum matches, sequence in range
        logic in_win;
        logic prev_win;
        logic at_base;
        logic del_last;   // current delivery ends the run
    } t_dp_status;

endpackage

>>> rtl/srr_dpath.sv
// ----------------------------------------------------------------------------
// srr_dpath: receiver datapath
// Serial checksum, window classification, slot store with held flags,
// receive base, delivery counter and the registered result beat.
// ----------------------------------------------------------------------------
module srr_dpath (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  srr_pkg::t_item               i_item,
    input  logic                         i_cfg_we,
    input  logic [srr_pkg::WIN_W-1:0]    i_cfg_data,
    input  srr_pkg::t_dp_cmd             i_cmd,
    output srr_pkg::t_dp_status          o_status,
    output logic                         o_strobe,
    output srr_pkg::t_result             o_result
);
    import srr_pkg::*;

    // captured item
    logic [SEQ_W-1:0]  r_seq;
    logic [DATA_W-1:0] r_payload;
    logic [CHK_W-1:0]  r_chk;

    // checksum state
    logic [BYTE_W-1:0] r_s1, n_s1;
    logic [BYTE_W-1:0] r_s2, n_s2;
    logic [BIDX_W-1:0] r_bidx;

    // window and receiver state
    logic [WIN_W-1:0]  r_win;
    logic [SEQ_W-1:0]  r_base;
    logic [SEQ_W-1:0]  base_next;
    logic [CNT_W-1:0]  r_cnt;
    logic [SLOT_DEPTH-1:0] r_held;
    logic [DATA_W-1:0] r_mem [SLOT_DEPTH];
    logic [DATA_W-1:0] r_rd;
    logic [SLOT_W-1:0] rd_addr;

    // output beat
    logic    r_strobe;
    t_result r_result;

    // window helpers
    logic [WIN_W-1:0]  w_eff;
    logic [SEQ_W:0]    d_raw;
    logic [SEQ_W:0]    seq_dist;
    logic [BYTE_W:0]   sum1;
    logic [BYTE_W:0]   sum2;
    logic [BYTE_W-1:0] cur_byte;

    // clamp window to 1..HALF_SPACE
    always_comb begin
        if (r_win == '0) begin
            w_eff = WIN_W'(1);
        end else if ({1'b0, r_win} > (WIN_W+1)'(HALF_SPACE)) begin
            w_eff = WIN_W'(HALF_SPACE);
        end else begin
            w_eff = r_win;
        end
    end

    // one checksum step: both sums reduced modulo 255 by compare-subtract
    always_comb begin
        cur_byte = r_payload[r_bidx*BYTE_W +: BYTE_W];
        sum1 = {1'b0, r_s1} + {1'b0, cur_byte};
        if (sum1 >= (BYTE_W+1)'(CSUM_MOD)) begin
            sum1 = sum1 - (BYTE_W+1)'(CSUM_MOD);
        end
        n_s1 = sum1[BYTE_W-1:0];
        sum2 = {1'b0, r_s2} + {1'b0, n_s1};
        if (sum2 >= (BYTE_W+1)'(CSUM_MOD)) begin
            sum2 = sum2 - (BYTE_W+1)'(CSUM_MOD);
        end
        n_s2 = sum2[BYTE_W-1:0];
    end

    // modular distance of the sequence number above the base
    always_comb begin
        d_raw = {1'b0, r_seq} + (SEQ_W+1)'(SEQ_SPACE) - {1'b0, r_base};
        if (d_raw >= (SEQ_W+1)'(SEQ_SPACE)) begin
            seq_dist = d_raw - (SEQ_W+1)'(SEQ_SPACE);
        end else begin
            seq_dist = d_raw;
        end
    end

    assign base_next = (r_base == SEQ_W'(SEQ_SPACE - 1)) ? '0 : r_base + SEQ_W'(1);
    assign rd_addr   = i_cmd.deliver ? SLOT_W'(base_next) : SLOT_W'(r_base);

    // status back to the controller
    always_comb begin
        o_status.csum_last = (r_bidx == BIDX_W'(NBYTES - 1));
        o_status.pkt_good  = ({r_s2, r_s1} == r_chk)
                             && ({1'b0, r_seq} < (SEQ_W+1)'(SEQ_SPACE));
        o_status.in_win    = seq_dist < (SEQ_W+1)'(w_eff);
        o_status.prev_win  = seq_dist >= ((SEQ_W+1)'(SEQ_SPACE) - (SEQ_W+1)'(w_eff));
        o_status.at_base   = (seq_dist == '0);
        o_status.del_last  = (({1'b0, r_cnt} + (CNT_W+1)'(1)) >= (CNT_W+1)'(w_eff))
                             || !r_held[SLOT_W'(base_next)];
    end

    // window register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win <= WIN_RESET;
        end else if (i_cfg_we) begin
            r_win <= i_cfg_data;
        end
    end

    // capture item and run the checksum
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_seq     <= i_item.seq_num;
            r_payload <= i_item.payload;
            r_chk     <= i_item.check_value;
            r_s1      <= '0;
            r_s2      <= '0;
            r_bidx    <= '0;
        end else if (i_cmd.csum_step) begin
            r_s1   <= n_s1;
            r_s2   <= n_s2;
            r_bidx <= r_bidx + BIDX_W'(1);
        end
    end

    // base, held flags and run counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base <= '0;
            r_held <= '0;
            r_cnt  <= '0;
        end else begin
            if (i_cmd.store && !r_held[SLOT_W'(r_seq)]) begin
                r_held[SLOT_W'(r_seq)] <= 1'b1;
            end
            if (i_cmd.rd_first) begin
                r_cnt <= '0;
            end
            if (i_cmd.deliver) begin
                r_held[SLOT_W'(r_base)] <= 1'b0;
                r_base <= base_next;
                r_cnt  <= r_cnt + CNT_W'(1);
            end
        end
    end

    // slot memory: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_cmd.store && !r_held[SLOT_W'(r_seq)]) begin
            r_mem[SLOT_W'(r_seq)] <= r_payload;
        end
        if (i_cmd.rd_first || i_cmd.deliver) begin
            r_rd <= r_mem[rd_addr];
        end
    end

    // result beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= i_cmd.ack || i_cmd.deliver;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.ack) begin
            r_result.kind        <= KIND_ACK;
            r_result.out_seq     <= r_seq;
            r_result.out_payload <= '0;
            r_result.last        <= i_cmd.ack_last;
        end else if (i_cmd.deliver) begin
            r_result.kind        <= KIND_DELIVER;
            r_result.out_seq     <= r_base;
            r_result.out_payload <= r_rd;
            r_result.last        <= o_status.del_last;
        end
    end

    assign o_strobe = r_strobe;
    assign o_result = r_result;

    // a delivery only ever takes a held slot
    a_deliver_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.deliver |-> r_held[SLOT_W'(r_base)])
        else $error("delivery from empty slot");

    // a run never exceeds the effective window
    a_run_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.deliver |-> ({1'b0, r_cnt} < (CNT_W+1)'(w_eff)))
        else $error("delivery run longer than window");

    // an acknowledgement that is not last is followed by a delivery beat
    a_ack_then_deliver: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_strobe && r_result.kind == KIND_ACK && !r_result.last)
        |-> ##2 (r_strobe && r_result.kind == KIND_DELIVER))
        else $error("non-final ack without delivery");

    // effective window stays within 1..HALF_SPACE
    a_win_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_eff != '0) && ({1'b0, w_eff} <= (WIN_W+1)'(HALF_SPACE)))
        else $error("effective window out of range");

endmodule

>>> rtl/srr_ctrl.sv
// ----------------------------------------------------------------------------
// srr_ctrl: receiver controller
// Sequences checksum, classification, store and the in-order delivery run.
// ----------------------------------------------------------------------------
module srr_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 start,
    output logic                 busy,
    input  srr_pkg::t_dp_status  i_status,
    output srr_pkg::t_dp_cmd     o_cmd
);
    import srr_pkg::*;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_CSUM  = 3'd1;
    localparam logic [2:0] ST_CLASS = 3'd2;
    localparam logic [2:0] ST_PREP  = 3'd3;
    localparam logic [2:0] ST_DELIV = 3'd4;

    logic [2:0] r_state, n_state;

    // next state and datapath commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            ST_IDLE: begin
                if (start) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_CSUM;
                end
            end
            ST_CSUM: begin
                o_cmd.csum_step = 1'b1;
                if (i_status.csum_last) begin
                    n_state = ST_CLASS;
                end
            end
            ST_CLASS: begin
                n_state = ST_IDLE;
                if (i_status.pkt_good) begin
                    if (i_status.in_win) begin
                        o_cmd.ack      = 1'b1;
                        o_cmd.ack_last = !i_status.at_base;
                        o_cmd.store    = 1'b1;
                        if (i_status.at_base) begin
                            n_state = ST_PREP;
                        end
                    end else if (i_status.prev_win) begin
                        o_cmd.ack      = 1'b1;
                        o_cmd.ack_last = 1'b1;
                    end
                end
            end
            ST_PREP: begin
                o_cmd.rd_first = 1'b1;
                n_state        = ST_DELIV;
            end
            ST_DELIV: begin
                o_cmd.deliver = 1'b1;
                if (i_status.del_last) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // hold state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign busy = (r_state != ST_IDLE);

endmodule

>>> rtl/selective_repeat_receiver_unit.sv
// ----------------------------------------------------------------------------
// selective_repeat_receiver_unit: selective repeat ARQ receive side
// Checks each data packet, acknowledges it and delivers payloads in order.
// ----------------------------------------------------------------------------
// Input beat: drive i_item and raise start; the beat is taken at an edge where
//   start is high and busy is low. busy then stays high until the item is done.
// Result beats: o_result is valid for one cycle while o_strobe is high. The
//   receiver must take every beat; it cannot stall the block. A good item in
//   the window or the window before it gives an acknowledgement first, then,
//   when it fills the window base, the run of held payloads in order; last
//   marks the final beat.
// Configuration: i_cfg_we with i_cfg_data writes the window width; write it
//   only while busy is low, as the block itself does not enforce this.
// Timing: the checksum folds one byte per cycle over the eight payload bytes,
//   then the classify state checks and stores the item; the ack beat is
//   registered from that state. A delivery run adds a slot read state, then
//   one payload beat per cycle, up to the window width. The next item is
//   taken only once busy is low again.
// Reset: synchronous, active low; clears the base and all held flags, window 15.
// ----------------------------------------------------------------------------
module selective_repeat_receiver_unit (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       start,
    output logic                       busy,
    input  srr_pkg::t_item             i_item,
    input  logic                       i_cfg_we,
    input  logic [srr_pkg::WIN_W-1:0]  i_cfg_data,
    output logic                       o_strobe,
    output srr_pkg::t_result           o_result
);
    import srr_pkg::*;

    t_dp_cmd    cmd;
    t_dp_status status;

    // sequencing
    srr_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_status (status),
        .o_cmd    (cmd)
    );

    // checksum, window, slots and result beat
    srr_dpath u_dpath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_item     (i_item),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_cmd      (cmd),
        .o_status   (status),
        .o_strobe   (o_strobe),
        .o_result   (o_result)
    );

endmodule
